### rtl/memory_region_interval_table_unit_defines.svh
// Assertion macros for the memory region interval table unit.
// No dependencies; included by files that carry concurrent assertions.
`ifndef MEMORY_REGION_INTERVAL_TABLE_UNIT_DEFINES_SVH
`define MEMORY_REGION_INTERVAL_TABLE_UNIT_DEFINES_SVH

// ante true at an edge implies cons at the same edge
`define MRIT_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// ante true at an edge implies cons at the next edge
`define MRIT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/mrit_pkg.sv
// Shared types and constants of the memory region interval table unit.
// No dependencies.
package mrit_pkg;

   localparam int MAX_BLOCKS_DEFAULT = 8;

   localparam int ADDR_W  = 32;
   localparam int FUNC_W  = 2;
   localparam int IDX_W   = 3;
   localparam int COUNT_W = 4;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 4'hF;

   // operation codes on the func field; the remaining code does nothing
   localparam logic [FUNC_W-1:0] FUNC_ADD  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_DEL  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_EVAL,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_READ_K,
      CMD_READ_IDX,
      CMD_EVAL,
      CMD_SHIFT_RD,
      CMD_SHIFT_WR,
      CMD_PLACE
   } cmd_type;

   // what one walk step does with the entry it fetched
   typedef enum logic [3:0] {
      OUT_APPEND,
      OUT_INSERT,
      OUT_MERGE,
      OUT_SKIP,
      OUT_STOP,
      OUT_TRIM,
      OUT_REMOVE,
      OUT_CUT,
      OUT_SPLIT
   } outcome_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              walk_done;
      outcome_type       outcome;
      logic              split_room;
      logic              shift_more;
      logic              shift_in;
      logic              out_free;
   } ctrl_status_type;

   typedef struct packed {
      cmd_type op;
      logic    respond;
   } ctrl_cmd_type;

endpackage

### rtl/mrit_channels.sv
// Request and response channel interfaces of the interval table unit.
// Depends on mrit_pkg.
interface mrit_req_if import mrit_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [ADDR_W-1:0] range_start;
   logic [ADDR_W-1:0] range_end;
   logic [IDX_W-1:0]  entry_index;

   modport source (output valid, func, range_start, range_end, entry_index, input ready);
   modport sink   (input valid, func, range_start, range_end, entry_index, output ready);
endinterface

interface mrit_rsp_if import mrit_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] occupied_count;
   logic [ADDR_W-1:0]  read_start;
   logic [ADDR_W-1:0]  read_end;

   modport source (output valid, occupied_count, read_start, read_end, input ready);
   modport sink   (input valid, occupied_count, read_start, read_end, output ready);
endinterface

### rtl/mrit_controller.sv
// Sequencing state machine of the interval table unit.
// Depends on mrit_pkg; drives the datapath by command, reads its status.
module mrit_controller import mrit_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      is_walk;

   assign is_walk = (status.func == FUNC_ADD) || (status.func == FUNC_DEL);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (is_walk && !status.walk_done) state_in = ST_EVAL;
            else                              state_in = ST_FINISH;
         end
         ST_EVAL: begin
            case (status.outcome)
               OUT_INSERT, OUT_REMOVE:        state_in = ST_SHIFT_RD;
               OUT_MERGE, OUT_SKIP, OUT_CUT:  state_in = ST_CHECK;
               OUT_SPLIT: state_in = status.split_room ? ST_SHIFT_RD : ST_FINISH;
               default:                       state_in = ST_FINISH;
            endcase
         end
         ST_SHIFT_RD: begin
            if (status.shift_more)    state_in = ST_SHIFT_WR;
            else if (status.shift_in) state_in = ST_FINISH;
            else                      state_in = ST_CHECK;
         end
         ST_SHIFT_WR: state_in = ST_SHIFT_RD;
         ST_FINISH: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready   = 1'b0;
      cmd.op      = CMD_NONE;
      cmd.respond = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = CMD_LOAD;
         end
         ST_CHECK: begin
            if (is_walk) begin
               if (!status.walk_done) cmd.op = CMD_READ_K;
            end else if (status.func == FUNC_READ) begin
               cmd.op = CMD_READ_IDX;
            end
         end
         ST_EVAL:     cmd.op = CMD_EVAL;
         ST_SHIFT_RD: cmd.op = status.shift_more ? CMD_SHIFT_RD : CMD_PLACE;
         ST_SHIFT_WR: cmd.op = CMD_SHIFT_WR;
         ST_FINISH:   cmd.respond = status.out_free;
         default:     cmd.op = CMD_NONE;
      endcase
   end

endmodule

### rtl/mrit_datapath.sv
// Table memory, walk registers and result register of the interval table unit.
// Depends on mrit_pkg; commanded by mrit_controller.
module mrit_datapath import mrit_pkg::*; #(
   parameter int MAX_BLOCKS = MAX_BLOCKS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  ctrl_cmd_type       cmd,
   output ctrl_status_type    status,
   input  logic [FUNC_W-1:0]  req_func,
   input  logic [ADDR_W-1:0]  req_start,
   input  logic [ADDR_W-1:0]  req_end,
   input  logic [IDX_W-1:0]   req_index,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [COUNT_W-1:0] rsp_count,
   output logic [ADDR_W-1:0]  rsp_start,
   output logic [ADDR_W-1:0]  rsp_end
);

   localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int KW = $clog2(MAX_BLOCKS + 1);
   localparam logic [KW-1:0]  MAX_K  = KW'(MAX_BLOCKS);
   localparam logic [KW-1:0]  LAST_K = KW'(MAX_BLOCKS - 1);
   localparam logic [KW-1:0]  ONE_K  = KW'(1);
   localparam logic [31:0]    MAX_U  = 32'(MAX_BLOCKS);

   // table storage: no reset, an entry without its valid bit reads as empty
   logic [ADDR_W-1:0]     mem_start_ff [MAX_BLOCKS];
   logic [ADDR_W-1:0]     mem_end_ff   [MAX_BLOCKS];
   logic [MAX_BLOCKS-1:0] valid_ff, valid_in;
   logic [KW-1:0]         count_ff, count_in;

   // request and walk registers
   logic [FUNC_W-1:0] func_ff, func_in;
   logic [ADDR_W-1:0] s_ff, s_in, e_ff, e_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic              idx_ok_ff, idx_ok_in;
   logic [KW-1:0]     k_ff, k_in, ptr_ff, ptr_in;
   logic              dir_in_ff, dir_in_in;
   logic [ADDR_W-1:0] pend_start_ff, pend_start_in, pend_end_ff, pend_end_in;

   // registered read port
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic [ADDR_W-1:0] rd_start_ff, rd_end_ff;
   logic              rd_valid_ff;

   // write port
   logic              wr_en, wr_valid;
   logic [AW-1:0]     wr_addr;
   logic [ADDR_W-1:0] wr_start, wr_end;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic [ADDR_W-1:0]  rsp_start_ff, rsp_end_ff;

   logic [ADDR_W-1:0] bs, be;
   outcome_type       outcome;
   logic [KW-1:0]     top_k;
   logic [AW-1:0]     k_addr, ptr_addr;
   logic              out_free;

   assign k_addr   = k_ff[AW-1:0];
   assign ptr_addr = ptr_ff[AW-1:0];
   assign bs       = rd_valid_ff ? rd_start_ff : '0;
   assign be       = rd_valid_ff ? rd_end_ff   : '0;
   assign top_k    = (count_ff < MAX_K) ? count_ff : LAST_K;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // decision for the fetched entry
   always_comb begin
      outcome = OUT_STOP;
      if (func_ff == FUNC_ADD) begin
         if (!rd_valid_ff)   outcome = OUT_APPEND;
         else if (e_ff < bs) outcome = OUT_INSERT;
         else if (s_ff < be) outcome = OUT_MERGE;
         else                outcome = OUT_SKIP;
      end else if (func_ff == FUNC_DEL) begin
         if (!rd_valid_ff || (e_ff < bs)) outcome = OUT_STOP;
         else if (s_ff < be) begin
            if (s_ff <= bs)      outcome = (e_ff < be) ? OUT_TRIM : OUT_REMOVE;
            else if (e_ff >= be) outcome = OUT_CUT;
            else                 outcome = OUT_SPLIT;
         end else begin
            outcome = OUT_SKIP;
         end
      end
   end

   always_comb begin
      status.func       = func_ff;
      status.walk_done  = (s_ff >= e_ff) || (k_ff >= MAX_K);
      status.outcome    = outcome;
      status.split_room = (k_ff + ONE_K) < MAX_K;
      status.shift_more = dir_in_ff ? (ptr_ff > k_ff) : ((ptr_ff + ONE_K) < count_ff);
      status.shift_in   = dir_in_ff;
      status.out_free   = out_free;
   end

   // register updates and port control
   always_comb begin
      func_in       = func_ff;
      s_in          = s_ff;
      e_in          = e_ff;
      idx_in        = idx_ff;
      idx_ok_in     = idx_ok_ff;
      k_in          = k_ff;
      ptr_in        = ptr_ff;
      dir_in_in     = dir_in_ff;
      pend_start_in = pend_start_ff;
      pend_end_in   = pend_end_ff;
      rd_en         = 1'b0;
      rd_addr       = k_addr;
      wr_en         = 1'b0;
      wr_valid      = 1'b1;
      wr_addr       = k_addr;
      wr_start      = s_ff;
      wr_end        = e_ff;
      case (cmd.op)
         CMD_LOAD: begin
            func_in   = req_func;
            s_in      = req_start;
            e_in      = req_end;
            idx_in    = AW'(req_index);
            idx_ok_in = 32'(req_index) < MAX_U;
            k_in      = '0;
         end
         CMD_READ_K: begin
            rd_en = 1'b1;
         end
         CMD_READ_IDX: begin
            rd_en   = 1'b1;
            rd_addr = idx_ff;
         end
         CMD_EVAL: begin
            case (outcome)
               OUT_APPEND: wr_en = 1'b1;
               OUT_INSERT: begin
                  pend_start_in = s_ff;
                  pend_end_in   = e_ff;
                  ptr_in        = top_k;
                  dir_in_in     = 1'b1;
               end
               OUT_MERGE: begin
                  wr_en    = 1'b1;
                  wr_start = (s_ff < bs) ? s_ff : bs;
                  wr_end   = be;
                  s_in     = be;
                  k_in     = k_ff + ONE_K;
               end
               OUT_SKIP: k_in = k_ff + ONE_K;
               OUT_TRIM: begin
                  wr_en    = 1'b1;
                  wr_start = e_ff;
                  wr_end   = be;
                  s_in     = e_ff;
               end
               OUT_REMOVE: begin
                  s_in      = be;
                  ptr_in    = k_ff;
                  dir_in_in = 1'b0;
               end
               OUT_CUT: begin
                  wr_en    = 1'b1;
                  wr_start = bs;
                  wr_end   = s_ff;
                  k_in     = k_ff + ONE_K;
               end
               OUT_SPLIT: begin
                  wr_en         = 1'b1;
                  wr_start      = bs;
                  wr_end        = s_ff;
                  pend_start_in = e_ff;
                  pend_end_in   = be;
                  k_in          = k_ff + ONE_K;
                  ptr_in        = top_k;
                  dir_in_in     = 1'b1;
               end
               default: ;
            endcase
         end
         CMD_SHIFT_RD: begin
            rd_en   = 1'b1;
            rd_addr = dir_in_ff ? AW'(ptr_ff - ONE_K) : AW'(ptr_ff + ONE_K);
         end
         CMD_SHIFT_WR: begin
            wr_en    = 1'b1;
            wr_addr  = ptr_addr;
            wr_start = rd_start_ff;
            wr_end   = rd_end_ff;
            wr_valid = rd_valid_ff;
            ptr_in   = dir_in_ff ? (ptr_ff - ONE_K) : (ptr_ff + ONE_K);
         end
         CMD_PLACE: begin
            wr_en = 1'b1;
            if (dir_in_ff) begin
               wr_start = pend_start_ff;
               wr_end   = pend_end_ff;
            end else begin
               // last occupied entry after a removal becomes empty
               wr_addr  = ptr_addr;
               wr_valid = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      if (wr_en) begin
         valid_in[wr_addr] = wr_valid;
         if (wr_valid && !valid_ff[wr_addr])      count_in = count_ff + ONE_K;
         else if (!wr_valid && valid_ff[wr_addr]) count_in = count_ff - ONE_K;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.respond)    rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         count_ff     <= '0;
         k_ff         <= '0;
         ptr_ff       <= '0;
         dir_in_ff    <= 1'b0;
         func_ff      <= FUNC_ADD;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         k_ff         <= k_in;
         ptr_ff       <= ptr_in;
         dir_in_ff    <= dir_in_in;
         func_ff      <= func_in;
         rsp_valid_ff <= rsp_valid_in;
         if (rd_en) rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      s_ff          <= s_in;
      e_ff          <= e_in;
      idx_ff        <= idx_in;
      idx_ok_ff     <= idx_ok_in;
      pend_start_ff <= pend_start_in;
      pend_end_ff   <= pend_end_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_start_ff[wr_addr] <= wr_start;
         mem_end_ff[wr_addr]   <= wr_end;
      end
      if (rd_en) begin
         rd_start_ff <= mem_start_ff[rd_addr];
         rd_end_ff   <= mem_end_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_count_ff <= (32'(count_ff) > 32'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(count_ff);
         if ((func_ff == FUNC_READ) && idx_ok_ff && rd_valid_ff) begin
            rsp_start_ff <= rd_start_ff;
            rsp_end_ff   <= rd_end_ff;
         end else begin
            rsp_start_ff <= '0;
            rsp_end_ff   <= '0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_count = rsp_count_ff;
   assign rsp_start = rsp_start_ff;
   assign rsp_end   = rsp_end_ff;

endmodule

### rtl/memory_region_interval_table_unit.sv
// Memory region interval table unit: sorted table of [start, end) address blocks.
// Requests add a range, delete a range or read one entry; every request gives one
// response with the occupied count (saturating at 15) and, for a read, the entry.
// Channels: req_ch (sink) and rsp_ch (source), valid/ready, a request moves on an
// edge where both are high. The unit takes one request at a time; req_ch.ready is
// high while the sequencer is idle, even when a response still waits in the
// output register, so a stalled receiver holds at most one finished response
// and the next request is walked meanwhile.
// A read or the unused code passes from the check state to the finish state.
// An add or delete walks the table: each entry examined is read in the check
// state and decided in the eval state, and a shift reads and writes each entry
// moved and then places the held entry or clears the freed one; the single read
// port of the table memory sets this order. The next request is taken the cycle
// after the response loads. A delete that removes a full table entry by entry
// is the worst case.
// Reset (synchronous, active high) clears the per-entry valid bits and the
// counters; the table reads as empty at once, no clearing pass.
// While rsp_ch.ready is low the response holds and a finished walk waits.
// Depends on mrit_pkg, mrit_channels, mrit_controller, mrit_datapath and the
// assertion macros header.
`include "memory_region_interval_table_unit_defines.svh"

module memory_region_interval_table_unit import mrit_pkg::*; #(
   parameter int MAX_BLOCKS = MAX_BLOCKS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   mrit_req_if.sink   req_ch,
   mrit_rsp_if.source rsp_ch
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // sequencer: fetch, decide, shift, respond
   mrit_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // table memory with valid bits, walk registers, response register
   mrit_datapath #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_func  (req_ch.func),
      .req_start (req_ch.range_start),
      .req_end   (req_ch.range_end),
      .req_index (req_ch.entry_index),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_count (rsp_ch.occupied_count),
      .rsp_start (rsp_ch.read_start),
      .rsp_end   (rsp_ch.read_end)
   );

   // a taken request makes the unit busy on the next cycle
   `MRIT_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_ch.valid && req_ch.ready, !req_ch.ready, "request accepted while busy")
   // a waiting response is never overwritten
   `MRIT_ASSERT_SAME(a_no_overwrite, clock, reset, cmd.respond, status.out_free, "response overwritten")
   // an entry returned by a read is either empty (zero) or a proper range
   `MRIT_ASSERT_SAME(a_read_entry_sane, clock, reset, rsp_ch.valid && ((rsp_ch.read_start != '0) || (rsp_ch.read_end != '0)), rsp_ch.read_start < rsp_ch.read_end, "bad entry read")

endmodule

### tb/mrit_table_checker.sv
// Checker for the memory region interval table unit: watches both channels,
// keeps its own copy of the block table and compares every response.
// Depends on mrit_pkg and the channel interfaces in mrit_channels.
module mrit_table_checker import mrit_pkg::*; #(
   parameter int MAX_BLOCKS = MAX_BLOCKS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   mrit_req_if  req_mon,
   mrit_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [COUNT_W-1:0] count;
      logic [ADDR_W-1:0]  rd_start;
      logic [ADDR_W-1:0]  rd_end;
   } table_status_type;

   table_status_type  status_q[$];
   logic [ADDR_W-1:0] region_lo [MAX_BLOCKS];
   logic [ADDR_W-1:0] region_hi [MAX_BLOCKS];

   initial fail_count = 0;
   initial pending = 0;

   function automatic void close_slot(int pos);
      for (int i = pos; i < MAX_BLOCKS - 1; i++) begin
         region_lo[i] = region_lo[i+1];
         region_hi[i] = region_hi[i+1];
      end
      region_lo[MAX_BLOCKS-1] = '0;
      region_hi[MAX_BLOCKS-1] = '0;
   endfunction

   // opens a slot at pos; whatever sat in the last slot is lost
   function automatic void open_slot(int pos, logic [ADDR_W-1:0] lo, logic [ADDR_W-1:0] hi);
      if (pos >= MAX_BLOCKS) return;
      for (int i = MAX_BLOCKS - 1; i > pos; i--) begin
         region_lo[i] = region_lo[i-1];
         region_hi[i] = region_hi[i-1];
      end
      region_lo[pos] = lo;
      region_hi[pos] = hi;
   endfunction

   function automatic void merge_range(logic [ADDR_W-1:0] lo_in, logic [ADDR_W-1:0] hi_in);
      logic [ADDR_W-1:0] lo, hi, bs, be;
      int k;
      lo = lo_in;
      hi = hi_in;
      k  = 0;
      while (lo < hi && k < MAX_BLOCKS) begin
         bs = region_lo[k];
         be = region_hi[k];
         if (bs >= be) begin
            region_lo[k] = lo;
            region_hi[k] = hi;
            break;
         end else if (hi < bs) begin
            open_slot(k, lo, hi);
            break;
         end else if (lo < be) begin
            // overlap or touch: grow downward, carry the rest past this block
            if (lo < bs) region_lo[k] = lo;
            lo = be;
         end else begin
            k++;
         end
      end
   endfunction

   function automatic void carve_range(logic [ADDR_W-1:0] lo_in, logic [ADDR_W-1:0] hi_in);
      logic [ADDR_W-1:0] lo, hi, bs, be, ns;
      int k;
      lo = lo_in;
      hi = hi_in;
      k  = 0;
      while (lo < hi && k < MAX_BLOCKS) begin
         bs = region_lo[k];
         be = region_hi[k];
         if (bs >= be || hi < bs) begin
            break;
         end else if (lo < be) begin
            if (lo <= bs) begin
               ns = (hi < be) ? hi : be;
               region_lo[k] = ns;
               lo = ns;
               if (ns >= be) close_slot(k);
            end else if (hi >= be) begin
               region_hi[k] = lo;
            end else begin
               // split; upper part drops off when k is the last slot
               region_hi[k] = lo;
               open_slot(k + 1, hi, be);
               break;
            end
         end else begin
            k++;
         end
      end
   endfunction

   function automatic logic [COUNT_W-1:0] occupied_blocks();
      int n;
      n = 0;
      for (int i = 0; i < MAX_BLOCKS; i++)
         if (region_lo[i] < region_hi[i]) n++;
      return (n > int'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(n);
   endfunction

   task automatic check_field(string name, logic [ADDR_W-1:0] exp_v, logic [ADDR_W-1:0] act_v);
      if (act_v !== exp_v) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      table_status_type st;
      if (reset) begin
         for (int i = 0; i < MAX_BLOCKS; i++) begin
            region_lo[i] = '0;
            region_hi[i] = '0;
         end
         status_q.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            st.rd_start = '0;
            st.rd_end   = '0;
            case (req_mon.func)
               FUNC_ADD: merge_range(req_mon.range_start, req_mon.range_end);
               FUNC_DEL: carve_range(req_mon.range_start, req_mon.range_end);
               FUNC_READ: begin
                  if (int'(req_mon.entry_index) < MAX_BLOCKS) begin
                     st.rd_start = region_lo[req_mon.entry_index];
                     st.rd_end   = region_hi[req_mon.entry_index];
                  end
               end
               default: ;
            endcase
            st.count = occupied_blocks();
            status_q.push_back(st);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (status_q.size() == 0) begin
               $display("%0t: response with nothing expected, actual count %0d start 0x%0h end 0x%0h",
                        $time, rsp_mon.occupied_count, rsp_mon.read_start, rsp_mon.read_end);
               fail_count++;
            end else begin
               st = status_q.pop_front();
               check_field("occupied_count", ADDR_W'(st.count), ADDR_W'(rsp_mon.occupied_count));
               check_field("read_start", st.rd_start, rsp_mon.read_start);
               check_field("read_end", st.rd_end, rsp_mon.read_end);
            end
         end
      end
      pending = status_q.size();
   end

endmodule

### tb/memory_region_interval_table_unit_tb.sv
// Top of the interval table testbench: clock, reset, request and response
// traffic, and the verdict. Depends on mrit_pkg, mrit_channels, the unit and
// mrit_table_checker.
module memory_region_interval_table_unit_tb;
   import mrit_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // the one code the package leaves unnamed; the unit must ignore it
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   localparam int RANDOM_ITEMS = 1830;
   localparam int HOLD_CYCLES  = 400;
   localparam int TAIL_CYCLES  = 100;      // longer than the slowest update
   localparam int CYCLE_LIMIT  = 600000;

   logic clock;
   logic reset;

   mrit_req_if req_ch ();
   mrit_rsp_if rsp_ch ();

   int  mismatch_total;
   int  in_flight;
   int  cycle_count;
   int  adds_sent, dels_sent, reads_sent, unused_sent;

   bit  no_gaps;     // both sides run without idling
   bit  hold_off;    // asks the receiver for one long stall

   // current address window for the random part
   logic [ADDR_W-1:0] win_base;
   int unsigned       win_span;

   memory_region_interval_table_unit u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   mrit_table_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .fail_count (mismatch_total),
      .pending    (in_flight)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Watchdog: a hung handshake or a lost response ends the run here.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d responses outstanding", cycle_count, in_flight);
      $display("Some tests failed");
      $finish;
   end

   // Receiver: random back-pressure, one long stall on request, none while
   // no_gaps is set. The stall length is counted here, not by the sender.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off = 1'b0;
         end else begin
            rsp_ch.ready <= no_gaps || ($urandom_range(0, 99) >= 21);
         end
      end
   end

   // Offers one request, idling first at random. Valid stays high into the
   // next call, which either lowers it or puts up the next request; ready is
   // sampled at the falling edge so the accept is known before the rising one.
   task automatic issue_request(logic [FUNC_W-1:0] f, logic [ADDR_W-1:0] lo,
                                logic [ADDR_W-1:0] hi, logic [IDX_W-1:0] idx);
      bit taken;
      while (!no_gaps && $urandom_range(0, 99) < 21) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.func        <= f;
      req_ch.range_start <= lo;
      req_ch.range_end   <= hi;
      req_ch.entry_index <= idx;
      do begin
         @(negedge clock);
         taken = req_ch.ready;
         @(posedge clock);
      end while (!taken);
      case (f)
         FUNC_ADD:  adds_sent++;
         FUNC_DEL:  dels_sent++;
         FUNC_READ: reads_sent++;
         default:   unused_sent++;
      endcase
   endtask

   // Sender goes quiet until every response is back; the count is sampled
   // at the falling edge, after the checker has settled it.
   task automatic drain_responses();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (in_flight != 0);
      @(posedge clock);
   endtask

   // Picks a fresh address window: low end, top end, or anywhere, with a
   // small span most of the time so ranges overlap, touch and nest.
   task automatic pick_window();
      case ($urandom_range(0, 3))
         0: win_span = 32'h1F;
         1: win_span = 32'h7F;
         2: win_span = 32'hFF;
         default: win_span = 32'hFFF;
      endcase
      case ($urandom_range(0, 3))
         0: win_base = '0;
         1: win_base = 32'hFFFF_FFFF - win_span;
         default: win_base = $urandom & 32'hFFFF_F000;
      endcase
   endtask

   task automatic random_request();
      logic [FUNC_W-1:0] f;
      logic [ADDR_W-1:0] a, b, t;
      int unsigned       pick;
      pick = $urandom_range(0, 99);
      a    = win_base + $urandom_range(0, win_span);
      b    = win_base + $urandom_range(0, win_span);
      if (pick < 8) begin
         // noise: any code, any addresses
         f = FUNC_W'($urandom_range(0, 3));
         a = $urandom;
         b = $urandom;
      end else if (pick < 13) begin
         // wide delete over the whole window
         f = FUNC_DEL;
         a = win_base;
         b = win_base + win_span;
      end else begin
         if (pick < 53)      f = FUNC_ADD;
         else if (pick < 75) f = FUNC_DEL;
         else if (pick < 96) f = FUNC_READ;
         else                f = FUNC_UNUSED;
         // mostly well-formed ranges, some reversed or empty
         if (a > b && $urandom_range(0, 99) < 85) begin
            t = a;
            a = b;
            b = t;
         end
      end
      issue_request(f, a, b, IDX_W'($urandom_range(0, 7)));
   endtask

   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.func        = FUNC_ADD;
      req_ch.range_start = '0;
      req_ch.range_end   = '0;
      req_ch.entry_index = '0;
      no_gaps            = 1'b0;
      hold_off           = 1'b0;
      adds_sent          = 0;
      dels_sent          = 0;
      reads_sent         = 0;
      unused_sent        = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      issue_request(FUNC_READ, '0, '0, 3'd0);               // read of empty table
      issue_request(FUNC_ADD, 32'h100, 32'h200, 3'd0);      // first block appended
      issue_request(FUNC_ADD, 32'h080, 32'h100, 3'd1);      // touching, grows downward
      issue_request(FUNC_ADD, 32'h300, 32'h400, 3'd2);      // append after
      issue_request(FUNC_ADD, 32'h010, 32'h020, 3'd3);      // insert in front
      issue_request(FUNC_ADD, 32'h1F0, 32'h350, 3'd4);      // spans two, carries remainder
      issue_request(FUNC_ADD, 32'h500, 32'h500, 3'd5);      // empty add
      issue_request(FUNC_DEL, 32'h600, 32'h400, 3'd6);      // reversed, empty delete
      issue_request(FUNC_DEL, 32'h000, 32'h010, 3'd7);      // ends at a block start
      issue_request(FUNC_DEL, 32'h010, 32'h018, 3'd0);      // trims the front
      issue_request(FUNC_DEL, 32'h018, 32'h020, 3'd1);      // trims to nothing, removed
      issue_request(FUNC_DEL, 32'h380, 32'h400, 3'd2);      // cuts the tail
      issue_request(FUNC_DEL, 32'h100, 32'h120, 3'd3);      // split in the middle
      issue_request(FUNC_ADD, 32'hFFFF_FF00, 32'hFFFF_FFFF, 3'd4); // top of space
      issue_request(FUNC_ADD, 32'h0000_0000, 32'h0000_0001, 3'd5); // bottom of space
      issue_request(FUNC_UNUSED, 32'hFFFF_FFFF, 32'h0, 3'd7);      // unused code
      // fill the table
      for (int i = 1; i <= 3; i++)
         issue_request(FUNC_ADD, 32'h10000 * i, 32'h10000 * i + 32'h40, IDX_W'(i));
      // split of the last slot with a full table: upper part is lost
      issue_request(FUNC_DEL, 32'hFFFF_FF80, 32'hFFFF_FF90, 3'd6);
      // insert behind the first block of a full table: last slot shifted out
      issue_request(FUNC_ADD, 32'h2, 32'h3, 3'd0);
      issue_request(FUNC_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd0);
      issue_request(FUNC_READ, '0, '0, 3'd7);

      // ---- random part ----
      pick_window();
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 99) pick_window();
         if (n == 300) hold_off = 1'b1;     // receiver stalls, unit backs up
         if (n == 900) drain_responses();   // sender waits out all responses
         no_gaps = (n >= 1200 && n < 1500);
         random_request();
      end

      drain_responses();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Ran %0d adds, %0d deletes, %0d reads and %0d unused-code requests",
               adds_sent, dels_sent, reads_sent, unused_sent);
      $display("in %0d cycles, through clustered, top-of-space and random address windows.",
               cycle_count);
      if (mismatch_total == 0 && in_flight == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
